>>> hw/rtl/rptg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rptg_pkg;

	// Width of the tick counter and of the running pulse width (16 to 32).
	localparam int TIMER_BITS = 21;
	// Lengths are compared at this width so no register value can overflow.
	localparam int CMP_W = 33;

	localparam logic [CMP_W-1:0] TMAX_C =
		{{(CMP_W-TIMER_BITS){1'b0}}, {TIMER_BITS{1'b1}}};

	localparam int CFG_AW = 3;
	localparam int CFG_DW = 20;

	typedef enum logic [CFG_AW-1:0] {
		REG_FIRST_WIDTH   = 3'd0,
		REG_WIDTH_STEP    = 3'd1,
		REG_GAP_TICKS     = 3'd2,
		REG_BASE_COUNT    = 3'd3,
		REG_EXTRA_COUNT   = 3'd4,
		REG_TRIGGER_TICKS = 3'd5,
		REG_END_DELAY     = 3'd6,
		REG_POLL_GAP      = 3'd7
	} rptg_reg_t;

	typedef enum logic [4:0] {
		PH_POLL = 5'b00001,
		PH_TRIG = 5'b00010,
		PH_HIGH = 5'b00100,
		PH_GAP  = 5'b01000,
		PH_END  = 5'b10000
	} rptg_phase_t;

	typedef struct packed {
		logic [15:0] first_width;
		logic [11:0] width_step;
		logic [15:0] gap_ticks;
		logic [6:0]  base_count;
		logic [6:0]  extra_count;
		logic [15:0] trigger_ticks;
		logic [19:0] end_delay;
		logic [15:0] poll_gap;
	} rptg_cfg_t;

	typedef struct packed {
		logic trigger_level;
		logic pulse_level;
		logic enabled;
		logic extended;
	} rptg_res_t;

	// Length of a phase: zero lasts one tick, long values clamp to the timer max.
	function automatic logic [CMP_W-1:0] span(input logic [CMP_W-1:0] len);
		logic [CMP_W-1:0] r;
		if (len == '0)
			r = CMP_W'(1);
		else if (len > TMAX_C)
			r = TMAX_C;
		else
			r = len;
		return r;
	endfunction

endpackage

`default_nettype wire

>>> hw/rtl/rptg_seq.sv
`timescale 1ns / 1ps
`default_nettype none

module rptg_seq
	import rptg_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      step,
	input  wire logic      button_one,
	input  wire logic      button_two,
	input  wire rptg_cfg_t cfg,
	output rptg_res_t      res
);

	rptg_phase_t           phase_q, phase_d;
	logic [TIMER_BITS-1:0] tick_q, tick_d;
	logic [7:0]            idx_q, idx_d;
	logic [TIMER_BITS-1:0] width_q, width_d;
	logic                  en_q, en_d;
	logic                  ex_q, ex_d;

	logic [CMP_W-1:0] tick_next;
	logic [CMP_W-1:0] lim;
	logic [CMP_W-1:0] width_sum;
	logic [7:0]       train_len;
	logic [7:0]       idx_inc;
	logic             last;
	logic             trig;
	logic             pulse;

	always_comb begin
		tick_next = CMP_W'(tick_q) + CMP_W'(1);
		case (phase_q)
			PH_TRIG: lim = span(CMP_W'(cfg.trigger_ticks));
			PH_HIGH: lim = span(CMP_W'(width_q));
			PH_GAP:  lim = span(CMP_W'(cfg.gap_ticks));
			PH_END:  lim = span(CMP_W'(cfg.end_delay));
			default: lim = span(CMP_W'(cfg.poll_gap));
		endcase
		last = (tick_next >= lim);

		train_len = 8'(cfg.base_count) + (ex_q ? 8'(cfg.extra_count) : 8'd0);
		idx_inc   = idx_q + 8'd1;
		width_sum = CMP_W'(width_q) + CMP_W'(cfg.width_step);

		phase_d = phase_q;
		tick_d  = last ? '0 : tick_next[TIMER_BITS-1:0];
		idx_d   = idx_q;
		width_d = width_q;
		en_d    = en_q;
		ex_d    = ex_q;
		trig    = 1'b0;
		pulse   = 1'b0;

		case (phase_q)
			PH_TRIG: begin
				trig = 1'b1;
				if (last) begin
					if (train_len == 8'd0)
						phase_d = (cfg.end_delay == '0) ? PH_POLL : PH_END;
					else
						phase_d = PH_HIGH;
				end
			end
			PH_HIGH: begin
				pulse = 1'b1;
				if (last)
					phase_d = PH_GAP;
			end
			PH_GAP: begin
				if (last) begin
					width_d = (width_sum > TMAX_C) ? TMAX_C[TIMER_BITS-1:0]
					                                : width_sum[TIMER_BITS-1:0];
					idx_d   = idx_inc;
					if (idx_inc >= train_len)
						phase_d = (cfg.end_delay == '0) ? PH_POLL : PH_END;
					else
						phase_d = PH_HIGH;
				end
			end
			PH_END: begin
				if (last)
					phase_d = PH_POLL;
			end
			default: begin
				// sampling point: buttons toggle the flags on the last poll tick
				if (last) begin
					en_d = en_q ^ button_one;
					ex_d = ex_q ^ button_two;
					if (en_d) begin
						phase_d = PH_TRIG;
						idx_d   = '0;
						width_d = TIMER_BITS'(cfg.first_width);
					end else begin
						phase_d = PH_POLL;
					end
				end
			end
		endcase

		res.trigger_level = trig;
		res.pulse_level   = pulse;
		res.enabled       = en_d;
		res.extended      = ex_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_POLL;
			tick_q  <= '0;
			idx_q   <= '0;
			width_q <= '0;
			en_q    <= 1'b0;
			ex_q    <= 1'b0;
		end else if (step) begin
			phase_q <= phase_d;
			tick_q  <= tick_d;
			idx_q   <= idx_d;
			width_q <= width_d;
			en_q    <= en_d;
			ex_q    <= ex_d;
		end
	end

	// the trigger and train phases are only reachable with output enabled
	a_trig_needs_en: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_TRIG || phase_q == PH_HIGH || phase_q == PH_GAP) |-> en_q)
		else $error("active phase with enable flag clear");

	a_flags_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(step && !(phase_q == PH_POLL && last)) |=> ($stable(en_q) && $stable(ex_q)))
		else $error("flag changed outside sampling point");

	a_tick_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		step |=> (CMP_W'(tick_q) <= TMAX_C))
		else $error("tick counter out of range");

endmodule

`default_nettype wire

>>> hw/rtl/ramped_pulse_train_generator.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Handshake                 Word
// s_*       in   s_tvalid / s_tready       tdata[1:0] = button_one, button_two
// m_*       out  m_tvalid / m_tready       tdata[3:0] = trigger_level, pulse_level,
//                                          enabled, extended
// cfg_*     in   cfg_valid / cfg_ready     cfg_addr = register index, cfg_data = value
//
// One tick word in, one level word out; sustained rate is one word per clock while m_tready stays high.
// A tick word passes the input register, then the phase sequencer updates and the
// result lands in the output register in the same edge.
// arst_n clears the sequencer to the poll gap with both flags low; registers
// return to their defaults.
// A stall on m_tready holds the result; the input register still takes a word while it
// is empty or while the output register is free or being drained.

module ramped_pulse_train_generator
	import rptg_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,

	input  wire logic              s_tvalid,
	output logic                   s_tready,
	input  wire logic [7:0]        s_tdata,   // [0] button_one, [1] button_two

	output logic                   m_tvalid,
	input  wire logic              m_tready,
	output logic [7:0]             m_tdata,   // [0] trigger_level, [1] pulse_level,
	                                          // [2] enabled, [3] extended

	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [CFG_AW-1:0] cfg_addr,
	input  wire logic [CFG_DW-1:0] cfg_data
);

	rptg_cfg_t cfg_q;
	rptg_res_t res;

	logic       s1_valid_q;
	logic [1:0] s1_btn_s1;
	logic       out_valid_q;
	logic [3:0] out_q;
	logic       adv;

	// registers take a write at any time; the block is idle by contract
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.first_width   <= 16'd1200;
			cfg_q.width_step    <= 12'd50;
			cfg_q.gap_ticks     <= 16'd600;
			cfg_q.base_count    <= 7'd10;
			cfg_q.extra_count   <= 7'd3;
			cfg_q.trigger_ticks <= 16'd50;
			cfg_q.end_delay     <= 20'd3000;
			cfg_q.poll_gap      <= 16'd100;
		end else if (cfg_valid) begin
			case (rptg_reg_t'(cfg_addr))
				REG_FIRST_WIDTH:   cfg_q.first_width   <= cfg_data[15:0];
				REG_WIDTH_STEP:    cfg_q.width_step    <= cfg_data[11:0];
				REG_GAP_TICKS:     cfg_q.gap_ticks     <= cfg_data[15:0];
				REG_BASE_COUNT:    cfg_q.base_count    <= cfg_data[6:0];
				REG_EXTRA_COUNT:   cfg_q.extra_count   <= cfg_data[6:0];
				REG_TRIGGER_TICKS: cfg_q.trigger_ticks <= cfg_data[15:0];
				REG_END_DELAY:     cfg_q.end_delay     <= cfg_data[19:0];
				REG_POLL_GAP:      cfg_q.poll_gap      <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// the held word advances whenever the output register is empty or draining
	assign adv      = s1_valid_q && (!out_valid_q || m_tready);
	assign s_tready = !s1_valid_q || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			s1_valid_q <= 1'b0;
		else if (s_tready)
			s1_valid_q <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready)
			s1_btn_s1 <= s_tdata[1:0];
	end

	rptg_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (adv),
		.button_one (s1_btn_s1[0]),
		.button_two (s1_btn_s1[1]),
		.cfg        (cfg_q),
		.res        (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (adv)
			out_valid_q <= 1'b1;
		else if (m_tready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (adv)
			out_q <= {res.extended, res.enabled, res.pulse_level, res.trigger_level};
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'd0, out_q};

	a_levels_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
		else $error("trigger and pulse high together");

	a_disabled_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tdata[2]) |-> (m_tdata[1:0] == 2'b00))
		else $error("pin driven while disabled");

	a_accept_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> s1_valid_q)
		else $error("accepted word lost");

endmodule

`default_nettype wire

>>> tb/ramped_pulse_train_generator_test.sv
`timescale 1ns / 1ps

module ramped_pulse_train_generator_test;
	import rptg_pkg::*;

	// Receiver hold-off used once to fill the block and stall its input.
	localparam int HOLD_CYCLES = 300;
	localparam int RAND_PHASES = 12;
	// Ticks spent with the width, step, gap, trigger and poll registers at their largest values.
	localparam int LONG_TICKS = 40;
	// Safety cap on the walk into the max end delay, well above what it needs.
	localparam int LONG_CAP = 200;
	localparam longint unsigned TIMER_MAX = (64'd1 << TIMER_BITS) - 64'd1;
	localparam int N_DIR = 29;
	localparam int N_REGS = 8;

	typedef enum int {
		SET_SMALL,
		SET_COUNTS,
		SET_MID,
		SET_ZERO
	} setting_kind_t;

	// One row of the directed plan: a register write or a tick word.
	typedef struct {
		bit                is_cfg;
		rptg_reg_t         cfg_sel;
		logic [CFG_DW-1:0] cfg_val;
		bit                b1;
		bit                b2;
		bit                typed;   // lv holds a hand-written expectation
		rptg_res_t         lv;
	} dir_row_t;

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              s_tvalid  = 1'b0;
	logic              s_tready;
	logic [7:0]        s_tdata   = '0;
	logic              m_tvalid;
	logic              m_tready  = 1'b0;
	logic [7:0]        m_tdata;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [CFG_AW-1:0] cfg_addr  = '0;
	logic [CFG_DW-1:0] cfg_data  = '0;

	// Shadow of the sequencer: register file, phase, counters and flags.
	rptg_cfg_t             shadow_cfg;
	rptg_phase_t           seq_phase;
	logic [TIMER_BITS-1:0] tick_cnt;
	logic [7:0]            pulse_idx;
	logic [TIMER_BITS-1:0] cur_width;
	bit                    en_flag;
	bit                    ext_flag;

	// Level words still owed by the block, oldest first.
	rptg_res_t levels_due[$];

	logic [CFG_DW-1:0] next_cfg [N_REGS];

	int fail_count    = 0;
	int tick_total    = 0;
	int frame_total   = 0;
	int pulse_total   = 0;
	int write_total   = 0;
	bit quiet_run     = 1'b0;   // no idling on either side
	bit hold_req      = 1'b0;

	// Directed plan. The first ticks sit inside the 100-tick poll gap after
	// reset, so every pin and flag is low whatever the buttons do. Then all
	// lengths go to zero (one-tick phases, empty train, skipped end delay),
	// then a short train with a one-tick end delay and a growing width.
	dir_row_t dir_plan [N_DIR] = '{
		'{1'b0, REG_FIRST_WIDTH,   20'd0, 1'b0, 1'b0, 1'b1, 4'b0000},
		'{1'b0, REG_FIRST_WIDTH,   20'd0, 1'b1, 1'b0, 1'b1, 4'b0000},
		'{1'b0, REG_FIRST_WIDTH,   20'd0, 1'b0, 1'b1, 1'b1, 4'b0000},
		'{1'b0, REG_FIRST_WIDTH,   20'd0, 1'b1, 1'b1, 1'b1, 4'b0000},
		'{1'b1, REG_POLL_GAP,      20'd0, 1'b0, 1'b0, 1'b0, 4'b0000},
		'{1'b1, REG_TRIGGER_TICKS, 20'd0, 1'b0, 1'b0, 1'b0, 4'b0000},
		'{1'b1, REG_BASE_COUNT,    20'd0, 1'b0, 1'b0, 1'b0, 4'b0000},
		'{1'b1, REG_EXTRA_COUNT,   20'd0, 1'b0, 1'b0, 1'b0, 4'b0000},
		'{1'b1, REG_END_DELAY,     20'd0, 1'b0, 1'b0, 1'b0, 4'b0000},
		'{1'b1, REG_FIRST_WIDTH,   20'd0, 1'b0, 1'b0, 1'b0, 4'b0000},
		'{1'b1, REG_WIDTH_STEP,    20'd0, 1'b0, 1'b0, 1'b0, 4'b0000},
		'{1'b1, REG_GAP_TICKS,     20'd0, 1'b0, 1'b0, 1'b0, 4'b0000},
		'{1'b0, REG_FIRST_WIDTH,   20'd0, 1'b1, 1'b0, 1'b0, 4'b0000},
		'{1'b0, REG_FIRST_WIDTH,   20'd0, 1'b0, 1'b0, 1'b0, 4'b0000},
		'{1'b0, REG_FIRST_WIDTH,   20'd0, 1'b1, 1'b1, 1'b0, 4'b0000},
		'{1'b0, REG_FIRST_WIDTH,   20'd0, 1'b0, 1'b0, 1'b0, 4'b0000},
		'{1'b0, REG_FIRST_WIDTH,   20'd0, 1'b0, 1'b1, 1'b0, 4'b0000},
		'{1'b0, REG_FIRST_WIDTH,   20'd0, 1'b1, 1'b0, 1'b0, 4'b0000},
		'{1'b1, REG_BASE_COUNT,    20'd2, 1'b0, 1'b0, 1'b0, 4'b0000},
		'{1'b1, REG_END_DELAY,     20'd1, 1'b0, 1'b0, 1'b0, 4'b0000},
		'{1'b1, REG_WIDTH_STEP,    20'd1, 1'b0, 1'b0, 1'b0, 4'b0000},
		'{1'b0, REG_FIRST_WIDTH,   20'd0, 1'b0, 1'b0, 1'b0, 4'b0000},
		'{1'b0, REG_FIRST_WIDTH,   20'd0, 1'b1, 1'b0, 1'b0, 4'b0000},
		'{1'b0, REG_FIRST_WIDTH,   20'd0, 1'b0, 1'b0, 1'b0, 4'b0000},
		'{1'b0, REG_FIRST_WIDTH,   20'd0, 1'b0, 1'b0, 1'b0, 4'b0000},
		'{1'b0, REG_FIRST_WIDTH,   20'd0, 1'b0, 1'b1, 1'b0, 4'b0000},
		'{1'b0, REG_FIRST_WIDTH,   20'd0, 1'b1, 1'b1, 1'b0, 4'b0000},
		'{1'b0, REG_FIRST_WIDTH,   20'd0, 1'b0, 1'b0, 1'b0, 4'b0000},
		'{1'b0, REG_FIRST_WIDTH,   20'd0, 1'b0, 1'b0, 1'b0, 4'b0000}
	};

	ramped_pulse_train_generator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_addr  (cfg_addr),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Hard stop; the slowest legal run is a small fraction of this.
	initial begin : watchdog
		#1_000_000;
		$display("[ramped_pulse_train_generator] ERROR");
		$finish;
	end

	// ---------------------------------------------------------------
	// Sequencer shadow
	// ---------------------------------------------------------------

	// Zero lasts one tick, anything past the timer range clamps.
	function automatic longint unsigned phase_len(input longint unsigned len);
		if (len == 0)
			return 64'd1;
		if (len > TIMER_MAX)
			return TIMER_MAX;
		return len;
	endfunction

	// One tick of a phase of length lim; true on its last tick.
	function automatic bit count_tick(input longint unsigned lim);
		longint unsigned nxt;
		nxt = 64'(tick_cnt) + 64'd1;
		if (nxt >= lim) begin
			tick_cnt = '0;
			return 1'b1;
		end
		tick_cnt = TIMER_BITS'(nxt);
		return 1'b0;
	endfunction

	// Counts are read live, so a write mid-train changes where it ends.
	function automatic int train_len();
		return 32'(shadow_cfg.base_count) + (ext_flag ? 32'(shadow_cfg.extra_count) : 0);
	endfunction

	function automatic void end_train();
		seq_phase = (shadow_cfg.end_delay == '0) ? PH_POLL : PH_END;
	endfunction

	// Advances the shadow by one tick word and returns the level word due.
	function automatic rptg_res_t step_levels(input bit b1, input bit b2);
		rptg_res_t       lv;
		longint unsigned grown;
		lv = '0;
		case (seq_phase)
			PH_TRIG: begin
				lv.trigger_level = 1'b1;
				if (count_tick(phase_len(64'(shadow_cfg.trigger_ticks)))) begin
					if (train_len() == 0) begin
						end_train();
					end else begin
						seq_phase = PH_HIGH;
						pulse_total++;
					end
				end
			end
			PH_HIGH: begin
				lv.pulse_level = 1'b1;
				if (count_tick(phase_len(64'(cur_width))))
					seq_phase = PH_GAP;
			end
			PH_GAP: begin
				if (count_tick(phase_len(64'(shadow_cfg.gap_ticks)))) begin
					// width grows after each gap and saturates at the timer max
					grown = 64'(cur_width) + 64'(shadow_cfg.width_step);
					cur_width = (grown > TIMER_MAX) ? TIMER_BITS'(TIMER_MAX)
					                                : TIMER_BITS'(grown);
					pulse_idx++;
					if (32'(pulse_idx) >= train_len()) begin
						end_train();
					end else begin
						seq_phase = PH_HIGH;
						pulse_total++;
					end
				end
			end
			PH_END: begin
				if (count_tick(phase_len(64'(shadow_cfg.end_delay))))
					seq_phase = PH_POLL;
			end
			default: begin
				// sampling point: last tick of the poll gap
				if (count_tick(phase_len(64'(shadow_cfg.poll_gap)))) begin
					en_flag  ^= b1;
					ext_flag ^= b2;
					if (en_flag) begin
						seq_phase = PH_TRIG;
						pulse_idx = '0;
						cur_width = TIMER_BITS'(shadow_cfg.first_width);
						frame_total++;
					end else begin
						seq_phase = PH_POLL;
					end
				end
			end
		endcase
		lv.enabled  = en_flag;
		lv.extended = ext_flag;
		return lv;
	endfunction

	// ---------------------------------------------------------------
	// Drivers
	// ---------------------------------------------------------------

	function automatic bit pick_idle();
		return !quiet_run && ($urandom_range(0, 99) < 30);
	endfunction

	// Random register value in [lo, hi].
	function automatic logic [CFG_DW-1:0] cfg_rand(input int unsigned lo,
	                                               input int unsigned hi);
		return CFG_DW'($urandom_range(hi, lo));
	endfunction

	task automatic report_mismatch(input string what);
		fail_count++;
		$display("mismatch @%0t: %s", $time, what);
	endtask

	// Entered at a falling edge; leaves at the falling edge after the word
	// is taken, with tvalid untouched so the next word can follow at once.
	task automatic send_tick(input bit b1, input bit b2, input bit typed,
	                         input rptg_res_t typed_lv);
		rptg_res_t lv;
		while (pick_idle()) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {6'b0, b2, b1};
		@(posedge clk);
		while (s_tready !== 1'b1)
			@(posedge clk);
		lv = step_levels(b1, b2);
		levels_due.push_back(typed ? typed_lv : lv);
		tick_total++;
		@(negedge clk);
	endtask

	// Block is idle once every owed level word has come back.
	task automatic settle();
		s_tvalid <= 1'b0;
		while (levels_due.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(input rptg_reg_t sel, input logic [CFG_DW-1:0] val);
		cfg_valid <= 1'b1;
		cfg_addr  <= sel;
		cfg_data  <= val;
		@(posedge clk);
		while (cfg_ready !== 1'b1)
			@(posedge clk);
		case (sel)
			REG_FIRST_WIDTH:   shadow_cfg.first_width   = val[15:0];
			REG_WIDTH_STEP:    shadow_cfg.width_step    = val[11:0];
			REG_GAP_TICKS:     shadow_cfg.gap_ticks     = val[15:0];
			REG_BASE_COUNT:    shadow_cfg.base_count    = val[6:0];
			REG_EXTRA_COUNT:   shadow_cfg.extra_count   = val[6:0];
			REG_TRIGGER_TICKS: shadow_cfg.trigger_ticks = val[15:0];
			REG_END_DELAY:     shadow_cfg.end_delay     = val[19:0];
			default:           shadow_cfg.poll_gap      = val[15:0];
		endcase
		write_total++;
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic load_setting();
		settle();
		for (int i = 0; i < N_REGS; i++)
			write_reg(rptg_reg_t'(i), next_cfg[i]);
	endtask

	// Random register set for one phase of the random part.
	task automatic pick_setting(input setting_kind_t kind);
		case (kind)
			SET_SMALL: begin
				next_cfg[REG_FIRST_WIDTH]   = cfg_rand(0, 6);
				next_cfg[REG_WIDTH_STEP]    = cfg_rand(0, 3);
				next_cfg[REG_GAP_TICKS]     = cfg_rand(0, 4);
				next_cfg[REG_BASE_COUNT]    = cfg_rand(0, 5);
				next_cfg[REG_EXTRA_COUNT]   = cfg_rand(0, 4);
				next_cfg[REG_TRIGGER_TICKS] = cfg_rand(0, 4);
				next_cfg[REG_END_DELAY]     = cfg_rand(0, 8);
				next_cfg[REG_POLL_GAP]      = cfg_rand(0, 5);
			end
			SET_COUNTS: begin
				// long trains of narrow pulses, counts up to the field max
				next_cfg[REG_FIRST_WIDTH]   = cfg_rand(0, 2);
				next_cfg[REG_WIDTH_STEP]    = '0;
				next_cfg[REG_GAP_TICKS]     = cfg_rand(0, 1);
				next_cfg[REG_BASE_COUNT]    = $urandom_range(0, 1) ? CFG_DW'(127)
				                                                   : cfg_rand(20, 126);
				next_cfg[REG_EXTRA_COUNT]   = $urandom_range(0, 1) ? CFG_DW'(127)
				                                                   : cfg_rand(0, 126);
				next_cfg[REG_TRIGGER_TICKS] = cfg_rand(0, 2);
				next_cfg[REG_END_DELAY]     = cfg_rand(0, 3);
				next_cfg[REG_POLL_GAP]      = cfg_rand(0, 2);
			end
			SET_MID: begin
				next_cfg[REG_FIRST_WIDTH]   = cfg_rand(1, 30);
				next_cfg[REG_WIDTH_STEP]    = cfg_rand(0, 10);
				next_cfg[REG_GAP_TICKS]     = cfg_rand(1, 20);
				next_cfg[REG_BASE_COUNT]    = cfg_rand(1, 6);
				next_cfg[REG_EXTRA_COUNT]   = cfg_rand(0, 6);
				next_cfg[REG_TRIGGER_TICKS] = cfg_rand(1, 20);
				next_cfg[REG_END_DELAY]     = cfg_rand(0, 40);
				next_cfg[REG_POLL_GAP]      = cfg_rand(1, 20);
			end
			default: begin
				for (int i = 0; i < N_REGS; i++)
					next_cfg[i] = '0;
			end
		endcase
		load_setting();
	endtask

	// ---------------------------------------------------------------
	// Receiver side: random stalls, plus one long hold-off on request
	// ---------------------------------------------------------------
	initial begin : drive_ready
		forever begin
			@(negedge clk);
			if (hold_req) begin
				m_tready <= 1'b0;
				hold_req <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			m_tready <= !pick_idle();
		end
	end

	// ---------------------------------------------------------------
	// Level word checker
	// ---------------------------------------------------------------
	always @(posedge clk) begin : check_levels
		rptg_res_t want;
		if (arst_n && m_tvalid === 1'b1 && m_tready) begin
			if (levels_due.size() == 0) begin
				report_mismatch($sformatf("level word %02h with no tick pending", m_tdata));
			end else begin
				want = levels_due.pop_front();
				if (m_tdata[3:0] !== {want.extended, want.enabled,
				                      want.pulse_level, want.trigger_level})
					report_mismatch($sformatf(
						"trig %b/%b pulse %b/%b en %b/%b ext %b/%b (got/want)",
						m_tdata[0], want.trigger_level, m_tdata[1], want.pulse_level,
						m_tdata[2], want.enabled, m_tdata[3], want.extended));
			end
		end
	end

	// ---------------------------------------------------------------
	// Stimulus
	// ---------------------------------------------------------------
	initial begin : run_ticks
		int n;
		int items;
		bit b1;
		bit b2;

		// register defaults and sequencer state after reset
		shadow_cfg = '{first_width: 16'd1200, width_step: 12'd50, gap_ticks: 16'd600,
		               base_count: 7'd10, extra_count: 7'd3, trigger_ticks: 16'd50,
		               end_delay: 20'd3000, poll_gap: 16'd100};
		seq_phase = PH_POLL;
		tick_cnt  = '0;
		pulse_idx = '0;
		cur_width = '0;
		en_flag   = 1'b0;
		ext_flag  = 1'b0;

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed plan
		foreach (dir_plan[i]) begin
			if (dir_plan[i].is_cfg) begin
				settle();
				write_reg(dir_plan[i].cfg_sel, dir_plan[i].cfg_val);
			end else begin
				send_tick(dir_plan[i].b1, dir_plan[i].b2, dir_plan[i].typed, dir_plan[i].lv);
			end
		end

		// Largest values the width, gap, trigger and poll fields allow, held for a
		// short stretch: the counters run against the widest limits, and the next
		// setting cuts the phase short while its count is already past the new length.
		next_cfg[REG_FIRST_WIDTH]   = 20'd65535;
		next_cfg[REG_WIDTH_STEP]    = 20'd4095;
		next_cfg[REG_GAP_TICKS]     = 20'd65535;
		next_cfg[REG_BASE_COUNT]    = 20'd1;
		next_cfg[REG_EXTRA_COUNT]   = 20'd0;
		next_cfg[REG_TRIGGER_TICKS] = 20'd65535;
		next_cfg[REG_END_DELAY]     = 20'd1;
		next_cfg[REG_POLL_GAP]      = 20'd65535;
		load_setting();
		for (int k = 0; k < LONG_TICKS; k++)
			send_tick(!en_flag, 1'($urandom_range(0, 1)), 1'b0, '0);

		// Max end delay, reached quickly with everything else at zero. The
		// first random setting shrinks it while the count is already past
		// the new length, so the delay must end on the next tick.
		for (int i = 0; i < N_REGS; i++)
			next_cfg[i] = '0;
		next_cfg[REG_END_DELAY] = 20'hFFFFF;
		load_setting();
		n = 0;
		while (!(seq_phase == PH_END && tick_cnt >= 16) && n < LONG_CAP) begin
			send_tick(!en_flag, 1'($urandom_range(0, 1)), 1'b0, '0);
			n++;
		end

		// random part
		for (int p = 0; p < RAND_PHASES; p++) begin
			pick_setting(setting_kind_t'(p % 4));
			quiet_run = (p == 5 || p == 6);
			if (p == 6)
				hold_req <= 1'b1;
			items = $urandom_range(115, 150);
			for (int k = 0; k < items; k++) begin
				if ($urandom_range(0, 9) == 0) begin
					// noise: buttons at random
					b1 = 1'($urandom_range(0, 1));
				end else begin
					// mostly keep output enabled, with the odd toggle off
					b1 = en_flag ? ($urandom_range(0, 7) == 0) : ($urandom_range(0, 3) != 0);
				end
				b2 = 1'($urandom_range(0, 1));
				send_tick(b1, b2, 1'b0, '0);
			end
		end
		quiet_run = 1'b0;

		settle();
		// keep clocking after the last owed word to catch stray words
		repeat (10) @(negedge clk);

		$display("covered %0d ticks: %0d frames, %0d pulses, %0d register writes",
		         tick_total, frame_total, pulse_total, write_total);
		$display("includes zero-length, max-value and mid-phase register cases; %0d mismatches",
		         fail_count);
		if (fail_count == 0)
			$display("[ramped_pulse_train_generator] OK");
		else
			$display("[ramped_pulse_train_generator] ERROR");
		$finish;
	end

endmodule

>>> sim.f
hw/rtl/rptg_pkg.sv
hw/rtl/rptg_seq.sv
hw/rtl/ramped_pulse_train_generator.sv
tb/ramped_pulse_train_generator_test.sv
